### sv/u16u8_pkg.sv
// Shared types, constants and the code point encoder of the UTF-16 to UTF-8 encoder.
package u16u8_pkg;

  localparam int unsigned UnitW     = 16;
  localparam int unsigned CpW       = 21;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned JobBytes  = 6;
  localparam int unsigned CntW      = 3;
  localparam int unsigned SurrW     = 10;
  localparam int unsigned FifoDepthDef = 2;

  localparam logic [UnitW-1:0] HiFirst  = 16'hD800;
  localparam logic [UnitW-1:0] HiLast   = 16'hDBFF;
  localparam logic [UnitW-1:0] LoFirst  = 16'hDC00;
  localparam logic [UnitW-1:0] LoLast   = 16'hDFFF;
  localparam logic [CpW-1:0]   SuppBase = 21'h10000;
  localparam logic [CpW-1:0]   OneLimit = 21'h80;
  localparam logic [CpW-1:0]   TwoLimit = 21'h800;
  localparam logic [ByteW-1:0] LeadTwo   = 8'hC0;
  localparam logic [ByteW-1:0] LeadThree = 8'hE0;
  localparam logic [ByteW-1:0] LeadFour  = 8'hF0;
  localparam logic [ByteW-1:0] ContMark  = 8'h80;
  localparam logic [5:0]       ContMask  = 6'h3F;

  // upper six bits of any high surrogate
  localparam logic [UnitW-SurrW-1:0] HiPrefix = HiFirst[UnitW-1:SurrW];

  typedef struct packed {
    logic [3:0][ByteW-1:0] bytes;
    logic [CntW-1:0]       len;
  } cp_enc_t;

  // one request from front to back: up to six bytes for one input item
  typedef struct packed {
    logic [JobBytes-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]                count;
    logic                           fin;
  } job_t;

  function automatic logic [ByteW-1:0] cont_byte(input logic [5:0] bits);
    cont_byte = ContMark | {2'b00, bits & ContMask};
  endfunction

  function automatic cp_enc_t enc_cp(input logic [CpW-1:0] cp);
    cp_enc_t e;
    e = '0;
    if (cp < OneLimit) begin
      e.bytes[0] = {1'b0, cp[6:0]};
      e.len      = 3'd1;
    end else if (cp < TwoLimit) begin
      e.bytes[0] = LeadTwo | {3'b000, cp[10:6]};
      e.bytes[1] = cont_byte(cp[5:0]);
      e.len      = 3'd2;
    end else if (cp < SuppBase) begin
      e.bytes[0] = LeadThree | {4'b0000, cp[15:12]};
      e.bytes[1] = cont_byte(cp[11:6]);
      e.bytes[2] = cont_byte(cp[5:0]);
      e.len      = 3'd3;
    end else begin
      e.bytes[0] = LeadFour | {5'b00000, cp[20:18]};
      e.bytes[1] = cont_byte(cp[17:12]);
      e.bytes[2] = cont_byte(cp[11:6]);
      e.bytes[3] = cont_byte(cp[5:0]);
      e.len      = 3'd4;
    end
    return e;
  endfunction

endpackage

### sv/u16u8_if.sv
// Valid/ready channel interfaces for code units in and UTF-8 bytes out.
interface u16u8_in_if;
  logic                          valid;
  logic                          ready;
  logic [u16u8_pkg::UnitW-1:0]   code_unit;
  logic                          final_unit;

  modport source (output valid, output code_unit, output final_unit, input ready);
  modport sink   (input valid, input code_unit, input final_unit, output ready);
endinterface

interface u16u8_out_if;
  logic                          valid;
  logic                          ready;
  logic [u16u8_pkg::ByteW-1:0]   out_byte;
  logic                          run_end;
  logic                          text_end;

  modport source (output valid, output out_byte, output run_end, output text_end, input ready);
  modport sink   (input valid, input out_byte, input run_end, input text_end, output ready);
endinterface

### sv/u16u8_fifo.sv
// Small register FIFO carrying byte requests from the front to the back.
module u16u8_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### sv/u16u8_front.sv
// Front end: accepts code units, pairs surrogates and builds byte requests.
module u16u8_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  u16u8_in_if.sink            in_i,
  output logic                push_o,
  output u16u8_pkg::job_t     job_o,
  input  logic                full_i
);

  logic                              held_valid_q, held_valid_d;
  logic [u16u8_pkg::SurrW-1:0]       held_high_q, held_high_d;
  logic                              accept;
  logic                              is_high, is_low, keep_high;
  logic [u16u8_pkg::CpW-1:0]         pair_cp;
  u16u8_pkg::cp_enc_t                enc_pair, enc_held, enc_unit;
  u16u8_pkg::job_t                   job;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;

  assign is_high = (in_i.code_unit >= u16u8_pkg::HiFirst) && (in_i.code_unit <= u16u8_pkg::HiLast);
  assign is_low  = (in_i.code_unit >= u16u8_pkg::LoFirst) && (in_i.code_unit <= u16u8_pkg::LoLast);
  assign keep_high = is_high && !in_i.final_unit;

  assign pair_cp = u16u8_pkg::SuppBase
                 + {1'b0, held_high_q, in_i.code_unit[u16u8_pkg::SurrW-1:0]};

  assign enc_pair = u16u8_pkg::enc_cp(pair_cp);
  assign enc_held = u16u8_pkg::enc_cp({5'b00000, u16u8_pkg::HiPrefix, held_high_q});
  assign enc_unit = u16u8_pkg::enc_cp({5'b00000, in_i.code_unit});

  always_comb begin
    job     = '0;
    job.fin = in_i.final_unit;
    if (held_valid_q && is_low) begin
      job.bytes[3:0] = enc_pair.bytes;
      job.count      = enc_pair.len;
    end else if (held_valid_q) begin
      // held surrogate goes out alone (always three bytes), then the unit unless it is held
      job.bytes[2:0] = enc_held.bytes[2:0];
      job.count      = 3'd3;
      if (!keep_high) begin
        job.bytes[5:3] = enc_unit.bytes[2:0];
        job.count      = 3'd3 + enc_unit.len;
      end
    end else if (!keep_high) begin
      job.bytes[3:0] = enc_unit.bytes;
      job.count      = enc_unit.len;
    end
  end

  assign job_o  = job;
  assign push_o = accept && (job.count != '0);

  always_comb begin
    held_valid_d = held_valid_q;
    held_high_d  = held_high_q;
    if (accept) begin
      held_valid_d = keep_high && !(held_valid_q && is_low);
      held_high_d  = held_valid_d ? in_i.code_unit[u16u8_pkg::SurrW-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_high_q  <= '0;
    end else begin
      held_valid_q <= held_valid_d;
      held_high_q  <= held_high_d;
    end
  end

endmodule

### sv/u16u8_back.sv
// Back end: sends the bytes of each request one per cycle while the receiver is ready, with end markers.
module u16u8_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  u16u8_pkg::job_t     job_i,
  output logic                pop_o,
  u16u8_out_if.source         out_o
);

  u16u8_pkg::job_t                cur_q, cur_d;
  logic                           busy_q, busy_d;
  logic [u16u8_pkg::CntW-1:0]     idx_q, idx_d;
  logic                           last, fire;

  assign last = (idx_q == cur_q.count - 3'd1);
  assign fire = out_o.valid && out_o.ready;

  assign out_o.valid    = busy_q;
  assign out_o.out_byte = cur_q.bytes[idx_q];
  assign out_o.run_end  = last;
  assign out_o.text_end = last && cur_q.fin;

  assign pop_o = valid_i && (!busy_q || (fire && last));

  always_comb begin
    cur_d  = cur_q;
    busy_d = busy_q;
    idx_d  = idx_q;
    if (pop_o) begin
      cur_d  = job_i;
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (fire) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

### sv/utf16_to_utf8_encoder.sv
// Top level of the UTF-16 to UTF-8 encoder.
//
// in_i carries one UTF-16 code unit per request with final_unit set on the
// last unit of a text. out_o returns UTF-8 bytes one per request; run_end
// marks the last byte caused by an input unit, text_end the last byte of
// the text. A non-final high surrogate produces no bytes until the next
// unit arrives; a pair becomes one 4-byte sequence, lone surrogates 3 bytes.
// Each accepted unit's request is first written into the request FIFO and
// then loaded into the output stage before its first byte is valid on out_o.
// Throughput: one output byte per cycle while the receiver is ready, set by
// the byte-wide output; a unit causes zero to six bytes. Units are
// accepted back to back while the request FIFO (FifoDepth entries) has room.
// When the receiver stalls the output holds and the FIFO fills, then
// in_i.ready drops. Reset clears the held surrogate, the FIFO and the output
// stage; no clearing pass is needed.
module utf16_to_utf8_encoder #(
  parameter int unsigned FifoDepth = u16u8_pkg::FifoDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  u16u8_in_if.sink     in_i,
  u16u8_out_if.source  out_o
);

  logic            push, full, pop, fifo_valid;
  u16u8_pkg::job_t push_job, head_job;

  u16u8_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .job_o  (push_job),
    .full_i (full)
  );

  u16u8_fifo #(
    .Width ($bits(u16u8_pkg::job_t)),
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (head_job),
    .valid_o (fifo_valid)
  );

  u16u8_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fifo_valid),
    .job_i   (head_job),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
